### design/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ascii formatter: the
// sequencer states, the conversion kind codes and the digit lookup.
// ---------------------------------------------------------------------------
package itoa_pkg;

  // conversion kind carried on req_type
  typedef enum logic [2:0] {
    KIND_RAW  = 3'd0,
    KIND_SDEC = 3'd1,
    KIND_UDEC = 3'd2,
    KIND_HEXL = 3'd3,
    KIND_HEXU = 3'd4
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT,
    ST_RAW
  } state_t;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_LA    = 8'h61;

  // one digit (0..15) to its ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ASCII_UA : ASCII_LA;
    if (d < 4'd10) begin
      digit_char = ASCII_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

### design/integer_to_ascii_formatter_top.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one value per input beat as ascii characters, most significant
// first, with a running character count on every output beat.
// ---------------------------------------------------------------------------
// One input beat is handled at a time; in_stall is high from acceptance until
// the last character has been loaded into the output register. Decimal kinds
// run a shift-and-add-3 binary to BCD converter, one value bit per cycle, until
// every value bit is in, then drop leading zero digits (at most NDIG - 1, NDIG
// = 10 at 32 bits) and settle on the leading digit, then emit each character
// (sign included) while the output side takes beats. Dropped zeros and emitted
// digits always add up to NDIG. Hex kinds skip the conversion. A raw kind
// emits the low byte of the value as its only character, marked as last.
// Unknown kinds are absorbed with no output.
module integer_to_ascii_formatter_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             req_type,
  input  logic [VALUE_WIDTH-1:0] value,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             ascii_char,
  output logic                   last_char,
  output logic [COUNT_WIDTH-1:0] running_count
);

  localparam int NDIG    = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BUF_W   = 4 * NDIG;
  localparam int DCNT_W  = $clog2(NDIG + 1);
  localparam int BCNT_W  = $clog2(VALUE_WIDTH + 1);

  itoa_pkg::state_t state, state_next;

  logic [VALUE_WIDTH-1:0] val;
  logic [BUF_W-1:0]       digs;
  logic [DCNT_W-1:0]      dig_cnt;
  logic [BCNT_W-1:0]      bit_cnt;
  logic                   neg;
  logic                   upper;
  logic [COUNT_WIDTH-1:0] count;

  logic                   in_accept;
  logic                   out_free;
  logic                   out_load;
  logic [7:0]             out_char;
  logic                   out_last;
  logic [3:0]             top_dig;
  logic [BUF_W-1:0]       dabbled;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   val_neg;
  itoa_pkg::kind_t        kind;

  assign in_stall  = (state != itoa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign top_dig   = digs[BUF_W-1 -: 4];
  assign kind      = itoa_pkg::kind_t'(req_type);
  assign val_neg   = (kind == itoa_pkg::KIND_SDEC) && value[VALUE_WIDTH-1];
  assign mag       = val_neg ? (~value + VALUE_WIDTH'(1)) : value;

  // add 3 to every BCD digit of five or more, ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (digs[4*i +: 4] >= 4'd5) begin
        dabbled[4*i +: 4] = digs[4*i +: 4] + 4'd3;
      end else begin
        dabbled[4*i +: 4] = digs[4*i +: 4];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (kind)
            itoa_pkg::KIND_RAW:  state_next = itoa_pkg::ST_RAW;
            itoa_pkg::KIND_SDEC,
            itoa_pkg::KIND_UDEC: state_next = itoa_pkg::ST_CONV;
            itoa_pkg::KIND_HEXL,
            itoa_pkg::KIND_HEXU: state_next = itoa_pkg::ST_SKIP;
            default:             state_next = itoa_pkg::ST_IDLE;
          endcase
        end
      end
      itoa_pkg::ST_CONV: begin
        if (bit_cnt == BCNT_W'(1)) state_next = itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SKIP: begin
        if (top_dig != 4'd0 || dig_cnt == DCNT_W'(1)) begin
          state_next = neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free && dig_cnt == DCNT_W'(1)) state_next = itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_RAW: begin
        if (out_free) state_next = itoa_pkg::ST_IDLE;
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  // character selection for the output register
  always_comb begin
    out_load = 1'b0;
    out_char = itoa_pkg::ASCII_ZERO;
    out_last = 1'b0;
    unique case (state)
      itoa_pkg::ST_SIGN: begin
        out_load = out_free;
        out_char = itoa_pkg::ASCII_MINUS;
      end
      itoa_pkg::ST_EMIT: begin
        out_load = out_free;
        out_char = itoa_pkg::digit_char(top_dig, upper);
        out_last = (dig_cnt == DCNT_W'(1));
      end
      itoa_pkg::ST_RAW: begin
        out_load = out_free;
        out_char = val[7:0];
        out_last = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itoa_pkg::ST_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        if (count != {COUNT_WIDTH{1'b1}}) count <= count + COUNT_WIDTH'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      ascii_char    <= out_char;
      last_char     <= out_last;
      running_count <= (count != {COUNT_WIDTH{1'b1}}) ? count + COUNT_WIDTH'(1) : count;
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_accept) begin
          val     <= mag;
          neg     <= val_neg;
          upper   <= (kind == itoa_pkg::KIND_HEXU);
          bit_cnt <= BCNT_W'(VALUE_WIDTH);
          dig_cnt <= DCNT_W'(NDIG);
          if (kind == itoa_pkg::KIND_HEXL || kind == itoa_pkg::KIND_HEXU) begin
            digs <= BUF_W'(value);
          end else begin
            digs <= '0;
          end
        end
      end
      itoa_pkg::ST_CONV: begin
        digs    <= {dabbled[BUF_W-2:0], val[VALUE_WIDTH-1]};
        val     <= {val[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - BCNT_W'(1);
      end
      itoa_pkg::ST_SKIP: begin
        if (top_dig == 4'd0 && dig_cnt != DCNT_W'(1)) begin
          digs    <= {digs[BUF_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DCNT_W'(1);
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free) begin
          digs    <= {digs[BUF_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DCNT_W'(1);
        end
      end
      default: begin
        digs <= digs;
      end
    endcase
  end

  // the count seen on successive beats never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (running_count >= $past(running_count)))
    else $error("running count decreased");

  // digits remain to be emitted whenever the emit state is active
  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_EMIT) |-> (dig_cnt != '0))
    else $error("emit state with no digits left");

  // a last character, from the emit or raw state, returns the block to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == itoa_pkg::ST_IDLE))
    else $error("last character loaded but sequencer not idle");

endmodule
